FILE: hw/rtl/fdp_pkg.sv
// Shared types, character codes and decimal tables of the decimal format printer.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package fdp_pkg;

   // Width of the per-string emitted-character counter
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Character codes
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_D       = 8'h64;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Decimal places of a 32-bit magnitude: 10^0 .. 10^9
   localparam int PLACE_W = 4;
   localparam int WIDE_W  = 34;

   // Command kinds handed from front to back
   typedef enum logic [1:0] {
      CMD_CHAR = 2'd0,   // emit the character as is
      CMD_NUM  = 2'd1,   // print the argument in decimal
      CMD_ERR  = 2'd2,   // bad specifier: one error item
      CMD_END  = 2'd3    // no item, only close the string
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
      logic [31:0]  arg;
      logic         last;
   } cmd_type;

   // Power of ten for a decimal place
   function automatic logic [WIDE_W-1:0] pow10(input logic [PLACE_W-1:0] place);
      logic [WIDE_W-1:0] val;
      unique case (place)
         4'd0:    val = 34'd1;
         4'd1:    val = 34'd10;
         4'd2:    val = 34'd100;
         4'd3:    val = 34'd1000;
         4'd4:    val = 34'd10000;
         4'd5:    val = 34'd100000;
         4'd6:    val = 34'd1000000;
         4'd7:    val = 34'd10000000;
         4'd8:    val = 34'd100000000;
         4'd9:    val = 34'd1000000000;
         default: val = '1;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/fdp_front.sv
// Front part of the decimal format printer: accepts format bytes and classifies them.
// Tracks the pending-percent and failed-string flags; pushes commands into fdp_queue.
module fdp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,    // [7:0] fmt_char, [39:8] arg_value
   input  logic             req_tlast,    // string_end
   input  logic             q_full,
   output logic             q_push,
   output fdp_pkg::cmd_type q_cmd
);

   logic       pending_ff, pending_in;
   logic       failed_ff, failed_in;
   logic       accept;
   logic [7:0] ch;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata[7:0];

   // Classify the byte against the string state
   always_comb begin
      pending_in  = pending_ff;
      failed_in   = failed_ff;
      q_push      = 1'b0;
      q_cmd.kind  = fdp_pkg::CMD_CHAR;
      q_cmd.ch    = ch;
      q_cmd.arg   = req_tdata[39:8];
      q_cmd.last  = req_tlast;
      if (accept) begin
         if (failed_ff) begin
            // drop the byte; the closing byte still resets the count
            q_push     = req_tlast;
            q_cmd.kind = fdp_pkg::CMD_END;
         end else if (pending_ff) begin
            pending_in = 1'b0;
            q_push     = 1'b1;
            if (ch == fdp_pkg::CH_D) begin
               q_cmd.kind = fdp_pkg::CMD_NUM;
            end else begin
               q_cmd.kind = fdp_pkg::CMD_ERR;
               failed_in  = 1'b1;
            end
         end else if (ch == fdp_pkg::CH_PERCENT) begin
            if (req_tlast) begin
               // percent with nothing after it
               q_push     = 1'b1;
               q_cmd.kind = fdp_pkg::CMD_ERR;
               failed_in  = 1'b1;
            end else begin
               pending_in = 1'b1;
            end
         end else begin
            q_push = 1'b1;
         end
         // return to the start-of-string state
         if (req_tlast) begin
            pending_in = 1'b0;
            failed_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

FILE: hw/rtl/fdp_queue.sv
// Short command queue between the front and the back of the decimal format printer.
// Holds fdp_pkg::cmd_type entries; depth from fdp_pkg::QUEUE_DEPTH.
module fdp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fdp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output fdp_pkg::cmd_type head_cmd
);

   fdp_pkg::cmd_type          entry_ff [fdp_pkg::QUEUE_DEPTH];
   logic [fdp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fdp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fdp_pkg::QPTR_W:0]   fill_ff, fill_in;
   logic                      do_push, do_pop;

   assign full       = (fill_ff == (fdp_pkg::QPTR_W+1)'(fdp_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/fdp_back.sv
// Back part of the decimal format printer: carries out queued commands.
// Emits characters, converts arguments to decimal digits and keeps the character count.
module fdp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  fdp_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,    // [7:0] out_char, [23:8] char_total
   output logic [1:0]       rsp_tuser,    // [0] error_flag, [1] run_last
   output logic             rsp_tlast     // string_done
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SIGN = 5'b00010,
      ST_SIZE = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [31:0]                      mag_ff, mag_in;
   logic [fdp_pkg::PLACE_W-1:0]      place_ff, place_in;
   logic [3:0]                       digit_ff, digit_in;
   logic [31:0]                      sub_ff, sub_in;
   logic                             last_ff, last_in;
   logic [fdp_pkg::COUNT_BITS-1:0]   count_ff, count_in, count_inc, count_view;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_char_ff;
   logic                             rsp_err_ff, rsp_run_ff, rsp_done_ff;
   logic [15:0]                      rsp_total_ff;

   logic                             out_free, out_load;
   logic [7:0]                       o_char;
   logic                             o_err, o_run, o_done;
   logic                             do_inc, do_clr;
   logic [fdp_pkg::PLACE_W-1:0]      size_cnt;
   logic [3:0]                       digit_cnt;
   logic [fdp_pkg::WIDE_W-1:0]       sub_sel, step_val, mag_wide;
   logic [31:0]                      count_ext;
   logic [15:0]                      o_total;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign mag_wide  = fdp_pkg::WIDE_W'(mag_ff);
   assign count_inc = (count_ff == fdp_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign count_view = do_inc ? count_inc : count_ff;
   assign count_ext = 32'(count_view);
   assign o_total   = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];

   // Find the top decimal place of the magnitude
   always_comb begin
      size_cnt = '0;
      for (int k = 1; k < 10; k++) begin
         if (mag_wide >= fdp_pkg::pow10(fdp_pkg::PLACE_W'(k))) begin
            size_cnt = size_cnt + 1'b1;
         end
      end
   end

   // Find the digit at the current place and the amount to take off
   always_comb begin
      digit_cnt = '0;
      sub_sel   = '0;
      step_val  = fdp_pkg::pow10(place_ff);
      for (int k = 1; k < 10; k++) begin
         if (mag_wide >= fdp_pkg::WIDE_W'(k) * step_val) begin
            digit_cnt = digit_cnt + 1'b1;
            sub_sel   = fdp_pkg::WIDE_W'(k) * step_val;
         end
      end
   end

   // Sequence the commands
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      place_in = place_ff;
      digit_in = digit_ff;
      sub_in   = sub_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;
      o_char   = '0;
      o_err    = 1'b0;
      o_run    = 1'b0;
      o_done   = 1'b0;
      do_inc   = 1'b0;
      do_clr   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  fdp_pkg::CMD_CHAR: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                        o_char   = q_cmd.ch;
                        o_run    = 1'b1;
                        o_done   = q_cmd.last;
                        do_inc   = 1'b1;
                        do_clr   = q_cmd.last;
                     end
                  end
                  fdp_pkg::CMD_ERR: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                        o_err    = 1'b1;
                        o_run    = 1'b1;
                        o_done   = 1'b1;
                        do_clr   = q_cmd.last;
                     end
                  end
                  fdp_pkg::CMD_END: begin
                     q_pop  = 1'b1;
                     do_clr = 1'b1;
                  end
                  fdp_pkg::CMD_NUM: begin
                     q_pop   = 1'b1;
                     last_in = q_cmd.last;
                     mag_in  = q_cmd.arg[31] ? 32'd0 - q_cmd.arg : q_cmd.arg;
                     state_in = q_cmd.arg[31] ? ST_SIGN : ST_SIZE;
                  end
               endcase
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_load = 1'b1;
               o_char   = fdp_pkg::CH_MINUS;
               do_inc   = 1'b1;
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            place_in = size_cnt;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            digit_in = digit_cnt;
            sub_in   = sub_sel[31:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               o_char   = fdp_pkg::CH_ZERO + 8'(digit_ff);
               do_inc   = 1'b1;
               mag_in   = mag_ff - sub_ff;
               if (place_ff == '0) begin
                  o_run    = 1'b1;
                  o_done   = last_ff;
                  do_clr   = last_ff;
                  state_in = ST_IDLE;
               end else begin
                  place_in = place_ff - 1'b1;
                  state_in = ST_CMP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Count emitted characters; clear at the end of the string
   always_comb begin
      if (do_clr) begin
         count_in = '0;
      end else begin
         count_in = count_view;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold conversion data and the output item
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      place_ff <= place_in;
      digit_ff <= digit_in;
      sub_ff   <= sub_in;
      last_ff  <= last_in;
      if (out_load) begin
         rsp_char_ff  <= o_char;
         rsp_err_ff   <= o_err;
         rsp_run_ff   <= o_run;
         rsp_done_ff  <= o_done;
         rsp_total_ff <= o_total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_char_ff};
   assign rsp_tuser  = {rsp_run_ff, rsp_err_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

FILE: hw/rtl/format_string_decimal_printer_core.sv
// Decimal format printer: takes a format string one byte per item, passes ordinary
// bytes through, prints the 32-bit signed argument in decimal for "%d", and flags any
// other specifier as an error that drops the rest of the string. A '%', or any byte
// after an error, makes no output. An ordinary byte or an error is handed out straight
// from the idle state of the back end; a "%d" gives a minus sign if the argument is
// negative, finds the top decimal place, and then takes a compare step and an emit step
// at each decimal place, for up to ten digits and a sign. The four-entry command
// queue lets the front keep taking bytes while a number is printed, and the output
// register lets a finished item wait while the next one is worked on.
module format_string_decimal_printer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // [7:0] fmt_char, [39:8] arg_value
   input  logic        req_tlast,    // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] out_char, [23:8] char_total
   output logic [1:0]  rsp_tuser,    // [0] error_flag, [1] run_last
   output logic        rsp_tlast     // string_done
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   fdp_pkg::cmd_type push_cmd;
   fdp_pkg::cmd_type head_cmd;

   // Classify incoming bytes
   fdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // Buffer commands
   fdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // Emit characters and digits
   fdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sim/format_string_decimal_printer_checker.sv
// Checker for the decimal format printer: watches the format-byte and result
// streams, predicts the printed items from each accepted byte and compares them.
// Depends on fdp_pkg for the counter width and the character codes.
`timescale 1ns / 1ps

module format_string_decimal_printer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,    // [7:0] fmt_char, [39:8] arg_value
   input  logic        req_tlast,    // string_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [7:0] out_char, [23:8] char_total
   input  logic [1:0]  rsp_tuser,    // [0] error_flag, [1] run_last
   input  logic        rsp_tlast,    // string_done
   output int          fail_count,
   output int          pending_count
);

   localparam int          MAX_REPORTS = 10;
   localparam logic [31:0] RADIX       = 32'd10;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        error_flag;
      logic        run_last;
      logic        string_done;
      logic [15:0] char_total;
   } print_item_type;

   // Printer state as seen from outside
   logic                           pct_seen;
   logic [fdp_pkg::COUNT_BITS-1:0] char_count;
   logic                           string_failed;

   print_item_type expected_chars[$];
   print_item_type step_items[$];

   task automatic clear_format_state();
      pct_seen      = 1'b0;
      char_count    = '0;
      string_failed = 1'b0;
   endtask

   // Add one printed item to this byte's batch, carrying the capped count
   task automatic add_item(input logic [7:0] ch, input logic err);
      print_item_type   it;
      longint unsigned  cnt;
      cnt            = char_count;
      it.out_char    = ch;
      it.error_flag  = err;
      it.run_last    = 1'b0;
      it.string_done = err;
      it.char_total  = (cnt > 64'hFFFF) ? 16'hFFFF : 16'(cnt);
      step_items.push_back(it);
   endtask

   task automatic print_char(input logic [7:0] ch);
      if (char_count != fdp_pkg::COUNT_MAX)
         char_count = char_count + 1'b1;
      add_item(ch, 1'b0);
   endtask

   // Work out the items caused by one format byte
   task automatic format_byte(input logic [7:0] ch, input logic [31:0] arg, input logic is_end);
      logic [31:0] mag;
      logic [3:0]  digits[$];
      step_items.delete();
      if (string_failed) begin
         // drop everything up to the end of the string
      end else if (pct_seen) begin
         pct_seen = 1'b0;
         if (ch == fdp_pkg::CH_D) begin
            mag = arg;
            if (arg[31]) begin
               print_char(fdp_pkg::CH_MINUS);
               mag = 32'd0 - arg;
            end
            do begin
               digits.push_front(4'(mag % RADIX));
               mag = mag / RADIX;
            end while (mag != 0);
            foreach (digits[i])
               print_char(fdp_pkg::CH_ZERO + 8'(digits[i]));
         end else begin
            add_item(8'h00, 1'b1);
            string_failed = 1'b1;
         end
      end else if (ch == fdp_pkg::CH_PERCENT) begin
         if (is_end) begin
            add_item(8'h00, 1'b1);
            string_failed = 1'b1;
         end else begin
            pct_seen = 1'b1;
         end
      end else begin
         print_char(ch);
      end

      // Mark the last item of the byte, and of the string
      if (step_items.size() > 0) begin
         step_items[step_items.size()-1].run_last = 1'b1;
         if (is_end)
            step_items[step_items.size()-1].string_done = 1'b1;
      end
      foreach (step_items[i])
         expected_chars.push_back(step_items[i]);
      if (is_end)
         clear_format_state();
   endtask

   // Compare one accepted result item with the oldest expectation
   task automatic check_output();
      print_item_type seen, want;
      seen.out_char    = rsp_tdata[7:0];
      seen.char_total  = rsp_tdata[23:8];
      seen.error_flag  = rsp_tuser[0];
      seen.run_last    = rsp_tuser[1];
      seen.string_done = rsp_tlast;
      if (expected_chars.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected item char %h err %b last %b done %b total %0d",
                     $time, seen.out_char, seen.error_flag, seen.run_last,
                     seen.string_done, seen.char_total);
      end else begin
         want = expected_chars.pop_front();
         if (seen !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $write("%0t: mismatch (expected/actual) char %h/%h err %b/%b ",
                      $time, want.out_char, seen.out_char,
                      want.error_flag, seen.error_flag);
               $display("last %b/%b done %b/%b total %0d/%0d",
                        want.run_last, seen.run_last,
                        want.string_done, seen.string_done,
                        want.char_total, seen.char_total);
            end
         end
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_format_state();
         expected_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_output();
         if (req_tvalid && req_tready)
            format_byte(req_tdata[7:0], req_tdata[39:8], req_tlast);
      end
      pending_count <= expected_chars.size();
   end

endmodule

FILE: sim/format_string_decimal_printer_core_test.sv
// Top of the decimal format printer testbench: clock, reset, format-string stimulus
// and the verdict. Instantiates format_string_decimal_printer_core and the checker;
// depends on fdp_pkg for the character codes.
`timescale 1ns / 1ps

module format_string_decimal_printer_core_test;

   localparam int          RANDOM_ITEMS = 290;
   localparam int          DRAIN_EVERY  = 110;
   localparam int          STEADY_BYTES = 12;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam logic [31:0] INT_MIN      = 32'h8000_0000;
   localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   bit tx_steady   = 1'b0;
   bit rx_steady   = 1'b0;

   logic [7:0] stall_mask = 8'hFF;
   logic [7:0] rx_cycle   = '0;

   always #6 clock = ~clock;

   format_string_decimal_printer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   format_string_decimal_printer_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Stall the result side on a random mask, reloaded whenever rx_cycle[4:0] is zero
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_cycle[4:0] == 5'd0)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      rsp_tready <= rx_steady | stall_mask[rx_cycle[2:0]];
   end

   // Give up after a generous number of cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one format byte, with a random gap between bursts
   task automatic send_item(input logic [7:0] ch, input logic [31:0] arg, input logic last);
      int gap;
      if (!tx_steady && burst_left <= 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {arg, ch};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Hold the sender until every expected item has come out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Any byte but a percent sign; a percent becomes NUL
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == fdp_pkg::CH_PERCENT)
         b = 8'h00;
      return b;
   endfunction

   // Argument for a %d, weighted toward extremes and digit-count boundaries
   function automatic logic [31:0] pick_arg();
      logic [31:0] v;
      case ($urandom_range(0, 9)) inside
         0:       v = INT_MIN;
         1:       v = INT_MAX;
         2:       v = 32'd0;
         3:       v = 32'($urandom_range(0, 20)) - 32'd10;
         [4:5]: begin
            v = 32'd1;
            repeat ($urandom_range(0, 9)) v = v * 32'd10;
            v = v - 32'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
               v = 32'd0 - v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // One random format string: mostly well-formed, some bad specifiers and noise
   task automatic send_random_string();
      int         ntok;
      int         pick;
      logic       last;
      logic [7:0] spec;
      ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      for (int t = 0; t < ntok; t++) begin
         last = (t == ntok - 1);
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_item(plain_byte(), $urandom, last);
         end else if (pick < 80) begin
            send_item(fdp_pkg::CH_PERCENT, $urandom, 1'b0);
            send_item(fdp_pkg::CH_D, pick_arg(), last);
         end else if (pick < 88) begin
            spec = 8'($urandom);
            if (spec == fdp_pkg::CH_D)
               spec = fdp_pkg::CH_PERCENT;
            send_item(fdp_pkg::CH_PERCENT, $urandom, 1'b0);
            send_item(spec, $urandom, last);
         end else if (pick < 93) begin
            send_item(fdp_pkg::CH_PERCENT, $urandom, last);
         end else begin
            send_item(8'($urandom), $urandom, last);
         end
      end
   endtask

   initial begin
      int random_start;
      int next_drain;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, zero and both int limits, error paths
      send_item(8'h00, $urandom, 1'b0);             // NUL passes through
      send_item(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_item(fdp_pkg::CH_D, 32'd0, 1'b0);        // d without percent
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, INT_MIN, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, INT_MAX, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, 32'hFFFF_FFFF, 1'b0);
      send_item(8'h78, 32'd0, 1'b1);
      // Double percent, then the rest of the string dropped
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, 32'd5, 1'b0);
      send_item(8'h62, 32'd0, 1'b1);
      // Percent at the end of the string
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b1);
      // Bad specifier on the last byte
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(8'h71, 32'd0, 1'b1);
      // Number on the last byte, then a one-byte string
      send_item(fdp_pkg::CH_PERCENT, 32'd0, 1'b0);
      send_item(fdp_pkg::CH_D, 32'd1000000000, 1'b1);
      send_item(8'h7A, 32'd0, 1'b1);
      wait_drained();

      // Back-to-back bytes with the receiver always ready
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      for (int n = 0; n < STEADY_BYTES; n++)
         send_item(plain_byte(), $urandom, 1'b0);
      send_item(fdp_pkg::CH_PERCENT, $urandom, 1'b0);
      send_item(fdp_pkg::CH_D, INT_MIN, 1'b0);
      send_item(8'h21, $urandom, 1'b1);
      wait_drained();
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      // Random strings, pausing now and then until everything has drained
      random_start = items_sent;
      next_drain   = items_sent + DRAIN_EVERY;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         send_random_string();
         if (items_sent >= next_drain) begin
            wait_drained();
            next_drain = items_sent + DRAIN_EVERY;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
